// ----- src/msop_pkg.sv -----
// ----------------------------------------------------------------------------
// msop_pkg
// Shared types and constants for the modular sum-of-products evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package msop_pkg;

    localparam int MOD_W   = 31;
    localparam int OPND_W  = 32;
    localparam int CNT_W   = 5;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    localparam logic [MOD_W-1:0] MODULUS_RESET = 31'd1000000007;

    // Register index of the modulus on the configuration port
    localparam logic REG_MODULUS = 1'b0;

    typedef enum logic [1:0] {
        FN_FIRST = 2'd0,
        FN_SUB   = 2'd1,
        FN_ADD   = 2'd2,
        FN_MUL   = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RSUM,
        S_RCUR,
        S_ROP,
        S_FIX,
        S_APPLY,
        S_MUL,
        S_FIN
    } t_state;

    // Configuration seen by the sequencer
    typedef struct packed {
        logic [MOD_W-1:0] modulus;
        logic             wr;
    } t_cfg;

endpackage

`default_nettype wire

// ----- src/msop_apb.sv -----
// ----------------------------------------------------------------------------
// msop_apb
// Configuration register file: holds the modulus, flags each write.
// ----------------------------------------------------------------------------
`default_nettype none

module msop_apb
    import msop_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output t_cfg                   o_cfg
);

    logic [MOD_W-1:0] r_modulus;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[ADDR_W-1] == REG_MODULUS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= MODULUS_RESET;
        end else if (wr_en) begin
            r_modulus <= pwdata[MOD_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[ADDR_W-1] == REG_MODULUS) begin
            prdata = {{(DATA_W-MOD_W){1'b0}}, r_modulus};
        end
    end

    assign o_cfg.modulus = r_modulus;
    assign o_cfg.wr      = wr_en;

endmodule

`default_nettype wire

// ----- src/msop_unit.sv -----
// ----------------------------------------------------------------------------
// msop_unit
// Shared modular step unit: one modular add, one double-plus-bit, one negate.
// ----------------------------------------------------------------------------
`default_nettype none

module msop_unit
    import msop_pkg::*;
(
    input  wire logic [MOD_W-1:0] i_mod,
    input  wire logic [MOD_W-1:0] i_a,
    input  wire logic [MOD_W-1:0] i_b,
    input  wire logic [MOD_W-1:0] i_c,
    input  wire logic             i_bit,
    output logic      [MOD_W-1:0] o_add,
    output logic      [MOD_W-1:0] o_dbl,
    output logic      [MOD_W-1:0] o_neg
);

    logic [MOD_W:0] m_ext;
    logic [MOD_W:0] sum_a;
    logic [MOD_W:0] sum_b;
    logic [MOD_W:0] red_a;
    logic [MOD_W:0] red_b;

    assign m_ext = {1'b0, i_mod};

    // a + b, both below the modulus: one conditional subtract
    assign sum_a = {1'b0, i_a} + {1'b0, i_b};
    assign red_a = (sum_a >= m_ext) ? (sum_a - m_ext) : sum_a;
    assign o_add = red_a[MOD_W-1:0];

    // 2c + bit: remainder step when bit is data, doubling when bit is zero
    assign sum_b = {i_c, i_bit};
    assign red_b = (sum_b >= m_ext) ? (sum_b - m_ext) : sum_b;
    assign o_dbl = red_b[MOD_W-1:0];

    assign o_neg = (i_c == '0) ? '0 : (i_mod - i_c);

endmodule

`default_nettype wire

// ----- src/msop_seq.sv -----
// ----------------------------------------------------------------------------
// msop_seq
// Sequencer and state registers; drives the shared step unit per state.
// ----------------------------------------------------------------------------
`default_nettype none

module msop_seq
    import msop_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  t_cfg                   i_cfg,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [1:0]        i_func,
    input  wire logic [OPND_W-1:0] i_operand,
    input  wire logic              i_last,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic      [MOD_W-1:0]  o_value
);

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    t_func             r_func, n_func;
    logic              r_last, n_last;
    logic              r_neg, n_neg;
    logic [OPND_W-1:0] r_mag, n_mag;
    logic [OPND_W-1:0] r_x, n_x;
    logic [MOD_W-1:0]  r_rem, n_rem;
    logic [MOD_W-1:0]  r_opnd, n_opnd;
    logic [MOD_W-1:0]  r_sum, n_sum;
    logic [MOD_W-1:0]  r_cur, n_cur;
    logic [MOD_W-1:0]  r_acc, n_acc;
    logic [MOD_W-1:0]  r_b, n_b;
    logic              r_dirty, n_dirty;
    logic              r_out_valid, n_out_valid;
    logic [MOD_W-1:0]  r_value, n_value;

    logic [MOD_W-1:0]  u_a, u_b, u_c;
    logic              u_bit;
    logic [MOD_W-1:0]  u_add, u_dbl, u_neg;
    logic              mod_zero;
    logic              accept;
    logic [OPND_W-1:0] mag_in;

    msop_unit u_unit (
        .i_mod (i_cfg.modulus),
        .i_a   (u_a),
        .i_b   (u_b),
        .i_c   (u_c),
        .i_bit (u_bit),
        .o_add (u_add),
        .o_dbl (u_dbl),
        .o_neg (u_neg)
    );

    // A modulus below two makes every residue zero
    assign mod_zero = (i_cfg.modulus < MOD_W'(2));
    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign mag_in   = i_operand[OPND_W-1] ? (~i_operand + OPND_W'(1)) : i_operand;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sum       <= '0;
            r_cur       <= '0;
            r_dirty     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sum       <= n_sum;
            r_cur       <= n_cur;
            r_dirty     <= n_dirty;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt   <= n_cnt;
        r_func  <= n_func;
        r_last  <= n_last;
        r_neg   <= n_neg;
        r_mag   <= n_mag;
        r_x     <= n_x;
        r_rem   <= n_rem;
        r_opnd  <= n_opnd;
        r_acc   <= n_acc;
        r_b     <= n_b;
        r_value <= n_value;
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_func      = r_func;
        n_last      = r_last;
        n_neg       = r_neg;
        n_mag       = r_mag;
        n_x         = r_x;
        n_rem       = r_rem;
        n_opnd      = r_opnd;
        n_sum       = r_sum;
        n_cur       = r_cur;
        n_acc       = r_acc;
        n_b         = r_b;
        n_dirty     = r_dirty || i_cfg.wr;
        n_out_valid = r_out_valid && !i_out_ready;
        n_value     = r_value;

        u_a   = r_sum;
        u_b   = r_cur;
        u_c   = r_rem;
        u_bit = r_x[OPND_W-1];

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_func  = t_func'(i_func);
                    n_last  = i_last;
                    n_neg   = i_operand[OPND_W-1] ^ (t_func'(i_func) == FN_SUB);
                    n_mag   = mag_in;
                    n_rem   = '0;
                    n_cnt   = CNT_W'(OPND_W - 1);
                    if (r_dirty) begin
                        n_x     = {{(OPND_W-MOD_W){1'b0}}, r_sum};
                        n_state = S_RSUM;
                    end else begin
                        n_x     = mag_in;
                        n_state = S_ROP;
                    end
                end
            end
            S_RSUM, S_RCUR, S_ROP: begin
                // one remainder bit per cycle, MSB first
                n_rem = u_dbl;
                n_x   = {r_x[OPND_W-2:0], 1'b0};
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    n_rem = '0;
                    n_cnt = CNT_W'(OPND_W - 1);
                    if (r_state == S_RSUM) begin
                        n_sum   = u_dbl;
                        n_x     = {{(OPND_W-MOD_W){1'b0}}, r_cur};
                        n_state = S_RCUR;
                    end else if (r_state == S_RCUR) begin
                        n_cur   = u_dbl;
                        n_dirty = i_cfg.wr;
                        n_x     = r_mag;
                        n_state = S_ROP;
                    end else begin
                        n_rem   = u_dbl;
                        n_state = S_FIX;
                    end
                end
            end
            S_FIX: begin
                n_opnd  = r_neg ? u_neg : r_rem;
                n_state = S_APPLY;
            end
            S_APPLY: begin
                case (r_func)
                    FN_FIRST: begin
                        n_sum   = '0;
                        n_cur   = r_opnd;
                        n_state = S_FIN;
                    end
                    FN_SUB, FN_ADD: begin
                        n_sum   = u_add;
                        n_cur   = r_opnd;
                        n_state = S_FIN;
                    end
                    default: begin
                        n_acc   = '0;
                        n_b     = r_cur;
                        n_cnt   = CNT_W'(MOD_W - 1);
                        n_state = S_MUL;
                    end
                endcase
            end
            S_MUL: begin
                // add-and-double, multiplier LSB first
                u_a   = r_acc;
                u_b   = r_b;
                u_c   = r_b;
                u_bit = 1'b0;
                n_acc  = r_opnd[0] ? u_add : r_acc;
                n_b    = u_dbl;
                n_opnd = {1'b0, r_opnd[MOD_W-1:1]};
                n_cnt  = r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    n_cur   = n_acc;
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_last) begin
                    if (mod_zero) begin
                        n_sum = '0;
                        n_cur = '0;
                    end
                    n_state = S_IDLE;
                end else if (!r_out_valid || i_out_ready) begin
                    n_value     = mod_zero ? '0 : u_add;
                    n_out_valid = 1'b1;
                    n_sum       = '0;
                    n_cur       = '0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_value     = r_value;

endmodule

`default_nettype wire

// ----- src/modular_sum_of_products_evaluator.sv -----
// ----------------------------------------------------------------------------
// modular_sum_of_products_evaluator
// Streams signed operands joined by subtract, add and multiply and returns
// the expression value modulo the configured modulus.
//
// Input words (func, operand, last) enter on a valid/ready channel; one word
// is worked on at a time and o_in_ready is low meanwhile. The operand is
// reduced one bit per cycle through a shared modular step unit, and a
// multiply runs add-and-double over 31 multiplier bits on that unit. After
// a modulus write, the next word first reduces the stored sum and term by
// the new modulus. A word with last set produces one result word on the
// output channel; the output register lets the next word be accepted while
// the result waits, and a second result holds the sequencer until the first
// is taken. Reset loads the modulus with 1000000007 and clears sum, term and
// the output valid flag. The user writes the modulus over the APB-style port
// only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module modular_sum_of_products_evaluator
    import msop_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [1:0]        i_func,
    input  wire logic [OPND_W-1:0] i_operand,
    input  wire logic              i_last,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic      [MOD_W-1:0]  o_value
);

    t_cfg cfg;

    msop_apb u_apb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    msop_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_func      (i_func),
        .i_operand   (i_operand),
        .i_last      (i_last),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_value     (o_value)
    );

endmodule

`default_nettype wire

// ----- dv/tb_modular_sum_of_products_evaluator.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_modular_sum_of_products_evaluator
// Drives expression words (func, operand, last) into the evaluator, predicts
// each expression value modulo the current modulus and compares every result
// word in order. The modulus is rewritten between phases over the APB-style
// port, sometimes mid-expression, and both channels stall at random.
// ----------------------------------------------------------------------------

module tb_modular_sum_of_products_evaluator;
    import msop_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 160;
    localparam int RAND_PHASES    = 10;
    localparam int PHASE_WORDS    = 108;
    localparam logic [ADDR_W-1:0] MOD_ADDR = ADDR_W'(4 * REG_MODULUS);

    typedef struct {
        t_func             fn;
        logic [OPND_W-1:0] opnd;
        logic              lst;
    } t_operand_word;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic [1:0]        i_func = FN_FIRST;
    logic [OPND_W-1:0] i_operand = '0;
    logic              i_last = 1'b0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [MOD_W-1:0]  o_value;

    modular_sum_of_products_evaluator uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_func     (i_func),
        .i_operand  (i_operand),
        .i_last     (i_last),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_value    (o_value)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Predictor state
    logic [MOD_W-1:0] mod_reg  = MODULUS_RESET;
    logic [MOD_W-1:0] sum_acc  = '0;
    logic [MOD_W-1:0] term_acc = '0;

    t_operand_word    word_queue[$];
    logic [MOD_W-1:0] pending_values[$];

    int  err_count = 0;
    int  words_sent = 0;
    int  values_checked = 0;
    int  mod_writes = 0;
    int  idle_cycles = 0;
    int  send_gap = 0;
    int  stall_left = 0;
    bit  idle_enable = 1'b1;
    bit  word_taken = 1'b0;

    function automatic longint unsigned mod_of(input longint unsigned x,
                                               input longint unsigned m);
        return (m == 0) ? 64'd0 : x % m;
    endfunction

    // Apply one word to the running sum and term; returns 1 with the value
    // when the word closes the expression.
    function automatic bit evaluate_word(input t_func fn, input logic [OPND_W-1:0] opnd,
                                         input logic lst, output logic [MOD_W-1:0] val);
        longint unsigned m;
        longint          sv;
        longint          rr;
        longint unsigned r;
        longint unsigned s;
        longint unsigned c;
        m  = (mod_reg < 2) ? 64'd0 : 64'(mod_reg);
        r  = 0;
        if (m != 0) begin
            sv = $signed(opnd);
            rr = sv % longint'(m);
            if (rr < 0)
                rr = rr + longint'(m);
            r = unsigned'(rr);
        end
        s = mod_of(64'(sum_acc), m);
        c = mod_of(64'(term_acc), m);
        case (fn)
            FN_FIRST: begin
                s = 0;
                c = r;
            end
            FN_SUB: begin
                s = mod_of(s + c, m);
                c = mod_of(m - r, m);
            end
            FN_ADD: begin
                s = mod_of(s + c, m);
                c = r;
            end
            default: begin
                c = mod_of(c * r, m);
            end
        endcase
        val = '0;
        if (lst) begin
            val      = MOD_W'(mod_of(s + c, m));
            sum_acc  = '0;
            term_acc = '0;
            return 1'b1;
        end
        sum_acc  = MOD_W'(s);
        term_acc = MOD_W'(c);
        return 1'b0;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (!idle_enable || roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 4);
        return $urandom_range(12, 48);
    endfunction

    // Sender: present the next word at the falling edge once the last one went
    always @(negedge i_clk) begin
        t_operand_word w;
        logic          next_valid;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || word_taken) begin
            next_valid = 1'b0;
            if (send_gap > 0) begin
                send_gap = send_gap - 1;
            end else if (word_queue.size() > 0) begin
                w = word_queue.pop_front();
                i_func    <= w.fn;
                i_operand <= w.opnd;
                i_last    <= w.lst;
                next_valid = 1'b1;
                send_gap   = pick_gap();
            end
            i_in_valid <= next_valid;
        end
    end

    // Receiver: random back-pressure on the result channel
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            if (idle_enable && $urandom_range(0, 3) == 0)
                stall_left = pick_gap();
            i_out_ready <= (stall_left == 0);
        end
    end

    // Monitor: predict on accepted input words, check result words
    always @(posedge i_clk) begin
        logic [MOD_W-1:0] val;
        logic [MOD_W-1:0] want;
        word_taken <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            words_sent <= words_sent + 1;
            if (evaluate_word(t_func'(i_func), i_operand, i_last, val))
                pending_values.push_back(val);
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_values.size() == 0) begin
                $display("%0t: result word %0d with none expected", $time, o_value);
                err_count <= err_count + 1;
            end else begin
                want = pending_values.pop_front();
                values_checked <= values_checked + 1;
                if (o_value !== want) begin
                    $display("%0t: value mismatch, expected %0d, got %0d",
                             $time, want, o_value);
                    err_count <= err_count + 1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (psel && penable && pready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired with %0d words queued and %0d values outstanding",
                     $time, word_queue.size(), pending_values.size());
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic push_word(input t_func fn, input logic [OPND_W-1:0] opnd, input logic lst);
        t_operand_word w;
        w.fn   = fn;
        w.opnd = opnd;
        w.lst  = lst;
        word_queue.push_back(w);
    endtask

    // Hold until every word has gone and every value has come, then let the
    // block finish any word that yields no result.
    task automatic wait_idle();
        while (word_queue.size() > 0 || i_in_valid || pending_values.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_modulus(input logic [DATA_W-1:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MOD_ADDR;
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        mod_reg    = val[MOD_W-1:0];
        mod_writes = mod_writes + 1;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata[MOD_W-1:0] !== mod_reg) begin
            $display("%0t: modulus readback mismatch, expected %0d, got %0d",
                     $time, mod_reg, prdata[MOD_W-1:0]);
            err_count = err_count + 1;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic [OPND_W-1:0] random_operand();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 25)
            return OPND_W'($urandom_range(0, 20) - 10);
        if (roll < 40) begin
            case ($urandom_range(0, 7))
                0: return 32'h8000_0000;
                1: return 32'h7fff_ffff;
                2: return 32'hffff_ffff;
                3: return 32'd0;
                4: return 32'd1;
                5: return OPND_W'(mod_reg) - 1;
                6: return OPND_W'(mod_reg);
                default: return -OPND_W'(mod_reg);
            endcase
        end
        return $urandom;
    endfunction

    // Queue well-formed expressions with random content plus some stray words
    task automatic queue_random_words(input int count);
        int n;
        int len;
        t_func fn;
        n = 0;
        while (n < count) begin
            if ($urandom_range(0, 9) == 0) begin
                push_word(t_func'($urandom_range(0, 3)), $urandom, 1'($urandom_range(0, 1)));
                n = n + 1;
            end else begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 14) : $urandom_range(1, 6);
                for (int k = 0; k < len && n < count; k++) begin
                    if (k == 0)
                        fn = ($urandom_range(0, 6) == 0) ? t_func'($urandom_range(1, 3)) : FN_FIRST;
                    else if ($urandom_range(0, 19) == 0)
                        fn = FN_FIRST;
                    else
                        fn = t_func'($urandom_range(1, 3));
                    push_word(fn, random_operand(), k == len - 1);
                    n = n + 1;
                end
            end
        end
    endtask

    initial begin
        logic [DATA_W-1:0] next_mod;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset modulus: extremes, negative operands, all operators
        push_word(FN_FIRST, 32'd0, 1'b1);
        push_word(FN_FIRST, 32'hffff_ffff, 1'b1);
        push_word(FN_FIRST, 32'h8000_0000, 1'b1);
        push_word(FN_FIRST, 32'h7fff_ffff, 1'b0);
        push_word(FN_MUL, 32'h7fff_ffff, 1'b0);
        push_word(FN_MUL, 32'hffff_ffff, 1'b0);
        push_word(FN_SUB, 32'h8000_0000, 1'b0);
        push_word(FN_ADD, 32'd5, 1'b0);
        push_word(FN_MUL, 32'h8000_0000, 1'b1);
        // expression that does not open with a first operand
        push_word(FN_ADD, 32'd7, 1'b0);
        push_word(FN_SUB, 32'hffff_fffd, 1'b1);
        // first operand in mid-expression drops the sum
        push_word(FN_FIRST, 32'd3, 1'b0);
        push_word(FN_ADD, 32'd4, 1'b0);
        push_word(FN_FIRST, 32'd9, 1'b0);
        push_word(FN_MUL, 32'd0, 1'b1);
        // leave an expression open across a modulus change
        push_word(FN_SUB, 32'd1, 1'b0);
        push_word(FN_MUL, 32'hffff_fff9, 1'b0);
        wait_idle();
        write_modulus(32'h7fff_ffff);
        push_word(FN_MUL, 32'd12345, 1'b0);
        push_word(FN_ADD, 32'hffff_ffff, 1'b1);
        push_word(FN_FIRST, 32'h8000_0000, 1'b0);
        push_word(FN_MUL, 32'h8000_0000, 1'b1);
        wait_idle();
        write_modulus(32'd2);
        push_word(FN_FIRST, 32'hffff_ffff, 1'b0);
        push_word(FN_SUB, 32'd3, 1'b0);
        push_word(FN_MUL, 32'h8000_0001, 1'b1);
        wait_idle();
        // degenerate moduli: everything collapses to zero
        write_modulus(32'd1);
        push_word(FN_FIRST, 32'd5, 1'b0);
        push_word(FN_ADD, 32'hffff_fff0, 1'b1);
        wait_idle();
        write_modulus(32'h8000_0000);
        push_word(FN_FIRST, 32'h7fff_ffff, 1'b0);
        push_word(FN_MUL, 32'd3, 1'b1);
        wait_idle();

        for (int p = 0; p < RAND_PHASES; p++) begin
            case (p)
                0: next_mod = 32'd1000000007;
                1: next_mod = 32'd2;
                2: next_mod = 32'h7fff_ffff;
                3: next_mod = 32'd3;
                4: next_mod = 32'h7fff_fffe;
                5: next_mod = 32'd65536;
                6: next_mod = $urandom_range(2, 1000);
                default: next_mod = $urandom_range(2, 32'h7fff_ffff);
            endcase
            // some phases run with no idling on either side
            idle_enable = (p % 3 != 2);
            write_modulus(next_mod);
            queue_random_words(PHASE_WORDS);
            wait_idle();
        end

        $display("Covered %0d input words and %0d checked values over %0d modulus writes",
                 words_sent, values_checked, mod_writes);
        if (err_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- modular_sum_of_products_evaluator.f -----
src/msop_pkg.sv
src/msop_apb.sv
src/msop_unit.sv
src/msop_seq.sv
src/modular_sum_of_products_evaluator.sv
dv/tb_modular_sum_of_products_evaluator.sv
